>>> rtl/core/sliding_piece_attack_generator_core_defines.svh
// Assertion macros for the sliding piece attack generator core.
`ifndef SLIDING_PIECE_ATTACK_GENERATOR_CORE_DEFINES_SVH
`define SLIDING_PIECE_ATTACK_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define SPAG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spag assertion failed: same-cycle implication");
// Next-cycle implication, disabled during reset.
`define SPAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spag assertion failed: next-cycle implication");
`else
`define SPAG_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SPAG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/core/spag_pkg.sv
// Shared types and command codes for the sliding piece attack generator.
package spag_pkg;

  localparam int BOARD_W = 64;
  localparam int SQ_W    = 6;
  localparam int CMD_W   = 3;

  localparam logic [CMD_W-1:0] CMD_BISHOP      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ROOK        = 3'd1;
  localparam logic [CMD_W-1:0] CMD_QUEEN       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_XRAY_BISHOP = 3'd3;
  localparam logic [CMD_W-1:0] CMD_XRAY_ROOK   = 3'd4;

  typedef logic [BOARD_W-1:0] board_t;

  // Bishop and rook attack sets for one square and occupancy.
  typedef struct packed {
    board_t bishop;
    board_t rook;
  } slider_set_t;

endpackage

>>> rtl/core/spag_line.sv
// Attacks along one line through the piece square by the subtraction trick.
module spag_line (
  input  logic [spag_pkg::SQ_W-1:0] square,
  input  spag_pkg::board_t          occupancy,
  input  spag_pkg::board_t          line,
  output spag_pkg::board_t          attacks
);

  function automatic spag_pkg::board_t bit_rev(input spag_pkg::board_t v);
    spag_pkg::board_t r;
    for (int i = 0; i < spag_pkg::BOARD_W; i++) begin
      r[i] = v[spag_pkg::BOARD_W-1-i];
    end
    return r;
  endfunction

  spag_pkg::board_t piece;
  spag_pkg::board_t occ_line;
  spag_pkg::board_t fwd;
  spag_pkg::board_t bwd_rev;

  assign piece    = spag_pkg::board_t'(1) << square;
  assign occ_line = occupancy & line;
  assign fwd      = occ_line - (piece << 1);
  // Same subtraction on the mirrored board covers the other direction.
  assign bwd_rev  = bit_rev(occ_line) - (bit_rev(piece) << 1);
  assign attacks  = (fwd ^ bit_rev(bwd_rev)) & line;

endmodule

>>> rtl/core/spag_slider.sv
// Bishop and rook attack sets from the four lines through a square.
module spag_slider (
  input  logic [spag_pkg::SQ_W-1:0] square,
  input  spag_pkg::board_t          occupancy,
  output spag_pkg::slider_set_t     sets
);

  localparam spag_pkg::board_t FILE_LINE = 64'h0101010101010101;
  localparam spag_pkg::board_t RANK_LINE = 64'h00000000000000ff;
  localparam spag_pkg::board_t DIAG_MAIN = 64'h8040201008040201;
  localparam spag_pkg::board_t ANTI_MAIN = 64'h0102040810204080;

  // Shift a diagonal by eight squares per unit of signed offset.
  function automatic spag_pkg::board_t shift_diag(input spag_pkg::board_t base,
                                                  input logic signed [3:0] d);
    logic signed [3:0] neg;
    neg = -d;
    if (!d[3]) begin
      return base << {d[2:0], 3'b000};
    end else begin
      return base >> {neg[2:0], 3'b000};
    end
  endfunction

  logic [2:0]        file;
  logic [2:0]        rank;
  logic signed [3:0] diag_off;
  logic signed [3:0] anti_off;
  spag_pkg::board_t  file_mask;
  spag_pkg::board_t  rank_mask;
  spag_pkg::board_t  diag_mask;
  spag_pkg::board_t  anti_mask;
  spag_pkg::board_t  file_att;
  spag_pkg::board_t  rank_att;
  spag_pkg::board_t  diag_att;
  spag_pkg::board_t  anti_att;

  assign file      = square[2:0];
  assign rank      = square[5:3];
  assign diag_off  = $signed({1'b0, rank}) - $signed({1'b0, file});
  assign anti_off  = $signed({1'b0, rank}) + $signed({1'b0, file}) - 4'sd7;
  assign file_mask = FILE_LINE << file;
  assign rank_mask = RANK_LINE << {rank, 3'b000};
  assign diag_mask = shift_diag(DIAG_MAIN, diag_off);
  assign anti_mask = shift_diag(ANTI_MAIN, anti_off);

  spag_line u_file (.square(square), .occupancy(occupancy), .line(file_mask),
                    .attacks(file_att));
  spag_line u_rank (.square(square), .occupancy(occupancy), .line(rank_mask),
                    .attacks(rank_att));
  spag_line u_diag (.square(square), .occupancy(occupancy), .line(diag_mask),
                    .attacks(diag_att));
  spag_line u_anti (.square(square), .occupancy(occupancy), .line(anti_mask),
                    .attacks(anti_att));

  assign sets.bishop = diag_att | anti_att;
  assign sets.rook   = file_att | rank_att;

endmodule

>>> rtl/core/sliding_piece_attack_generator_core.sv
// Top level: three-stage sliding piece attack pipeline with x-ray support.
//
// One transaction is taken on every clock edge with start high; busy is always low.
// The attack board appears on attacks, done high for exactly one cycle, after the
// input, middle and output registers; the receiver cannot stall, results are never
// held. Stage one registers the request, stage two resolves the first attack pass
// and folds the x-ray blockers into the occupancy, stage three resolves the second
// pass and forms the result; the two chained line-subtractor passes set the depth.
`include "sliding_piece_attack_generator_core_defines.svh"

module sliding_piece_attack_generator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [spag_pkg::CMD_W-1:0]     command,
  input  logic [spag_pkg::SQ_W-1:0]      square,
  input  logic [spag_pkg::BOARD_W-1:0]   occupancy,
  input  logic [spag_pkg::BOARD_W-1:0]   blockers,
  output logic [spag_pkg::BOARD_W-1:0]   attacks,
  output logic                           done
);

  // Input register
  logic                         in_valid;
  logic [spag_pkg::CMD_W-1:0]   in_cmd;
  logic [spag_pkg::SQ_W-1:0]    in_sq;
  spag_pkg::board_t             in_occ;
  spag_pkg::board_t             in_blk;

  // Middle register
  logic                         mid_valid;
  logic [spag_pkg::CMD_W-1:0]   mid_cmd;
  logic [spag_pkg::SQ_W-1:0]    mid_square;
  spag_pkg::board_t             mid_first;
  spag_pkg::board_t             mid_occ;

  spag_pkg::slider_set_t        pass1;
  spag_pkg::slider_set_t        pass2;
  spag_pkg::board_t             first_next;
  spag_pkg::board_t             attacks_next;

  // The pipeline never stalls.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_cmd <= command;
    in_sq  <= square;
    in_occ <= occupancy;
    in_blk <= blockers;
  end

  spag_slider u_pass1 (.square(in_sq), .occupancy(in_occ), .sets(pass1));

  always_comb begin
    unique case (in_cmd)
      spag_pkg::CMD_BISHOP:      first_next = pass1.bishop;
      spag_pkg::CMD_ROOK:        first_next = pass1.rook;
      spag_pkg::CMD_QUEEN:       first_next = pass1.bishop | pass1.rook;
      spag_pkg::CMD_XRAY_BISHOP: first_next = pass1.bishop;
      spag_pkg::CMD_XRAY_ROOK:   first_next = pass1.rook;
      default:                   first_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else begin
      mid_valid <= in_valid;
    end
    mid_cmd    <= in_cmd;
    mid_square <= in_sq;
    mid_first  <= first_next;
    // Toggle the blockers hit by the first pass for the x-ray pass.
    mid_occ    <= in_occ ^ (in_blk & first_next);
  end

  spag_slider u_pass2 (.square(mid_square), .occupancy(mid_occ), .sets(pass2));

  always_comb begin
    unique case (mid_cmd)
      spag_pkg::CMD_XRAY_BISHOP: attacks_next = mid_first ^ pass2.bishop;
      spag_pkg::CMD_XRAY_ROOK:   attacks_next = mid_first ^ pass2.rook;
      default:                   attacks_next = mid_first;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= mid_valid;
    end
    attacks <= attacks_next;
  end

  `SPAG_ASSERT_NEXT(a_accept_fills_input, clk, rst, start && !busy, in_valid)
  `SPAG_ASSERT_NEXT(a_mid_yields_done, clk, rst, mid_valid, done)
  `SPAG_ASSERT_NEXT(a_unused_cmd_empty, clk, rst,
    mid_valid && (mid_cmd != spag_pkg::CMD_BISHOP) && (mid_cmd != spag_pkg::CMD_ROOK) &&
    (mid_cmd != spag_pkg::CMD_QUEEN) && (mid_cmd != spag_pkg::CMD_XRAY_BISHOP) &&
    (mid_cmd != spag_pkg::CMD_XRAY_ROOK), attacks == '0)
  `SPAG_ASSERT_NEXT(a_own_square_clear, clk, rst, mid_valid,
    (attacks & (spag_pkg::board_t'(1) << $past(mid_square))) == '0)
  `SPAG_ASSERT_NEXT(a_plain_cmd_passes_first, clk, rst,
    mid_valid && (mid_cmd == spag_pkg::CMD_QUEEN), attacks == $past(mid_first))

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the sliding piece attack generator core.
`timescale 1ns / 100ps

module testbench;

  localparam logic [spag_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [spag_pkg::CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [spag_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  localparam spag_pkg::board_t EMPTY_BOARD = 64'h0000000000000000;
  localparam spag_pkg::board_t FULL_BOARD  = 64'hffffffffffffffff;
  localparam spag_pkg::board_t FILE_A      = 64'h0101010101010101;
  localparam spag_pkg::board_t RANK_1      = 64'h00000000000000ff;
  localparam spag_pkg::board_t DIAG_A1H8   = 64'h8040201008040201;
  localparam spag_pkg::board_t DIAG_H1A8   = 64'h0102040810204080;

  localparam int DIRECTED_ROWS = 21;
  localparam int PHASE_ITEMS   = 250;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [spag_pkg::CMD_W-1:0] cmd;
    logic [spag_pkg::SQ_W-1:0]  sq;
    spag_pkg::board_t           occ;
    spag_pkg::board_t           blk;
    logic                       known;
    spag_pkg::board_t           want;
  } stim_row_t;

  typedef struct {
    logic [spag_pkg::CMD_W-1:0] cmd;
    logic [spag_pkg::SQ_W-1:0]  sq;
    spag_pkg::board_t           attacks;
  } pending_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic [spag_pkg::CMD_W-1:0] command = spag_pkg::CMD_BISHOP;
  logic [spag_pkg::SQ_W-1:0]  square = '0;
  spag_pkg::board_t           occupancy = EMPTY_BOARD;
  spag_pkg::board_t           blockers = EMPTY_BOARD;
  logic                       busy;
  spag_pkg::board_t           attacks;
  logic                       done;

  pending_t  pending_attacks [$];
  stim_row_t directed_rows [DIRECTED_ROWS];
  int        gap_pct = 0;
  int        cycle_count = 0;
  int        mismatches = 0;
  int        sent = 0;
  int        checked = 0;
  int        xray_sent = 0;

  sliding_piece_attack_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .square    (square),
    .occupancy (occupancy),
    .blockers  (blockers),
    .attacks   (attacks),
    .done      (done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Full 64-bit bit reversal by swapping ever wider fields.
  function automatic spag_pkg::board_t mirror_board(spag_pkg::board_t v);
    v = ((v & 64'h5555555555555555) << 1) | ((v >> 1) & 64'h5555555555555555);
    v = ((v & 64'h3333333333333333) << 2) | ((v >> 2) & 64'h3333333333333333);
    v = ((v & 64'h0f0f0f0f0f0f0f0f) << 4) | ((v >> 4) & 64'h0f0f0f0f0f0f0f0f);
    v = ((v & 64'h00ff00ff00ff00ff) << 8) | ((v >> 8) & 64'h00ff00ff00ff00ff);
    return (v << 48) | ((v & 64'h00000000ffff0000) << 16) |
           ((v >> 16) & 64'h00000000ffff0000) | (v >> 48);
  endfunction

  function automatic spag_pkg::board_t line_reach(logic [spag_pkg::SQ_W-1:0] sq,
                                                  spag_pkg::board_t occ,
                                                  spag_pkg::board_t line);
    spag_pkg::board_t piece, o, fwd, bwd;
    piece = spag_pkg::board_t'(1) << sq;
    o     = occ & line;
    fwd   = o - (piece << 1);
    bwd   = mirror_board(mirror_board(o) - (mirror_board(piece) << 1));
    return (fwd ^ bwd) & line;
  endfunction

  // Move a diagonal mask up (d > 0) or down (d < 0) by whole ranks.
  function automatic spag_pkg::board_t slide_diag(spag_pkg::board_t base, int d);
    if (d >= 0) begin
      return base << (8 * d);
    end
    return base >> (-8 * d);
  endfunction

  function automatic spag_pkg::board_t bishop_reach(logic [spag_pkg::SQ_W-1:0] sq,
                                                    spag_pkg::board_t occ);
    int rnk, fil;
    rnk = int'(sq[5:3]);
    fil = int'(sq[2:0]);
    return line_reach(sq, occ, slide_diag(DIAG_A1H8, rnk - fil)) |
           line_reach(sq, occ, slide_diag(DIAG_H1A8, rnk + fil - 7));
  endfunction

  function automatic spag_pkg::board_t rook_reach(logic [spag_pkg::SQ_W-1:0] sq,
                                                  spag_pkg::board_t occ);
    int rnk, fil;
    rnk = int'(sq[5:3]);
    fil = int'(sq[2:0]);
    return line_reach(sq, occ, FILE_A << fil) | line_reach(sq, occ, RANK_1 << (8 * rnk));
  endfunction

  function automatic spag_pkg::board_t slider_reach(logic rook,
                                                    logic [spag_pkg::SQ_W-1:0] sq,
                                                    spag_pkg::board_t occ);
    return rook ? rook_reach(sq, occ) : bishop_reach(sq, occ);
  endfunction

  // Toggle the blockers hit by the first pass, look again, keep what differs.
  function automatic spag_pkg::board_t xray_reach(logic rook,
                                                  logic [spag_pkg::SQ_W-1:0] sq,
                                                  spag_pkg::board_t occ,
                                                  spag_pkg::board_t blk);
    spag_pkg::board_t first;
    first = slider_reach(rook, sq, occ);
    return first ^ slider_reach(rook, sq, occ ^ (blk & first));
  endfunction

  function automatic spag_pkg::board_t predict_attacks(logic [spag_pkg::CMD_W-1:0] cmd,
                                                       logic [spag_pkg::SQ_W-1:0] sq,
                                                       spag_pkg::board_t occ,
                                                       spag_pkg::board_t blk);
    case (cmd)
      spag_pkg::CMD_BISHOP:      return bishop_reach(sq, occ);
      spag_pkg::CMD_ROOK:        return rook_reach(sq, occ);
      spag_pkg::CMD_QUEEN:       return bishop_reach(sq, occ) | rook_reach(sq, occ);
      spag_pkg::CMD_XRAY_BISHOP: return xray_reach(1'b0, sq, occ, blk);
      spag_pkg::CMD_XRAY_ROOK:   return xray_reach(1'b1, sq, occ, blk);
      default:                   return EMPTY_BOARD;
    endcase
  endfunction

  // Mix of densities; sparse boards give long rays.
  function automatic spag_pkg::board_t sample_board();
    spag_pkg::board_t a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return a & b & c;
      1:       return a & b;
      2:       return a;
      default: return a | b;
    endcase
  endfunction

  // Present one query, hold it until taken, then log what it should produce.
  task automatic issue(logic [spag_pkg::CMD_W-1:0] cmd, logic [spag_pkg::SQ_W-1:0] sq,
                       spag_pkg::board_t occ, spag_pkg::board_t blk, logic known,
                       spag_pkg::board_t want);
    pending_t entry;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    command   <= cmd;
    square    <= sq;
    occupancy <= occ;
    blockers  <= blk;
    do @(posedge clk); while (busy);
    entry.cmd     = cmd;
    entry.sq      = sq;
    entry.attacks = known ? want : predict_attacks(cmd, sq, occ, blk);
    pending_attacks.insert(pending_attacks.size(), entry);
    sent++;
    if (cmd == spag_pkg::CMD_XRAY_BISHOP || cmd == spag_pkg::CMD_XRAY_ROOK) begin
      xray_sent++;
    end
  endtask

  // Lower start and hold off until every logged transaction has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_attacks.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    pending_t head;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_attacks.size());
      $display("FAILED: results differ");
      $finish;
    end else if (!rst && done) begin
      if (pending_attacks.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, attacks);
      end else begin
        head = pending_attacks.pop_front();
        checked++;
        if (attacks !== head.attacks) begin
          mismatches++;
          $display("%0t: attacks mismatch cmd=%0d sq=%0d expected %h actual %h",
                   $time, head.cmd, head.sq, head.attacks, attacks);
        end
      end
    end
  end

  initial begin
    stim_row_t                  row;
    logic [spag_pkg::CMD_W-1:0] cmd;
    logic [spag_pkg::SQ_W-1:0]  sq;
    spag_pkg::board_t           occ, blk;
    int                         phase, i;

    directed_rows[0]  = '{spag_pkg::CMD_BISHOP, 6'd0, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h8040201008040200};
    directed_rows[1]  = '{spag_pkg::CMD_ROOK, 6'd0, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h01010101010101fe};
    directed_rows[2]  = '{spag_pkg::CMD_QUEEN, 6'd0, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h81412111090503fe};
    directed_rows[3]  = '{spag_pkg::CMD_BISHOP, 6'd63, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h0040201008040201};
    directed_rows[4]  = '{spag_pkg::CMD_ROOK, 6'd63, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h7f80808080808080};
    directed_rows[5]  = '{spag_pkg::CMD_ROOK, 6'd0, FULL_BOARD, EMPTY_BOARD, 1'b1,
                          64'h0000000000000102};
    directed_rows[6]  = '{spag_pkg::CMD_BISHOP, 6'd0, FULL_BOARD, FULL_BOARD, 1'b1,
                          64'h0000000000000200};
    directed_rows[7]  = '{spag_pkg::CMD_XRAY_ROOK, 6'd0, FULL_BOARD, FULL_BOARD, 1'b1,
                          64'h0000000000010004};
    directed_rows[8]  = '{CMD_SPARE_5, 6'd27, FULL_BOARD, FULL_BOARD, 1'b1, EMPTY_BOARD};
    directed_rows[9]  = '{CMD_SPARE_6, 6'd0, 64'h5555555555555555, FULL_BOARD, 1'b1,
                          EMPTY_BOARD};
    directed_rows[10] = '{CMD_SPARE_7, 6'd63, EMPTY_BOARD, FULL_BOARD, 1'b1, EMPTY_BOARD};
    directed_rows[11] = '{spag_pkg::CMD_BISHOP, 6'd7, EMPTY_BOARD, EMPTY_BOARD, 1'b1,
                          64'h0102040810204000};
    directed_rows[12] = '{spag_pkg::CMD_QUEEN, 6'd27, FULL_BOARD, EMPTY_BOARD, 1'b0,
                          EMPTY_BOARD};
    // Same rook query with and without its own square occupied.
    directed_rows[13] = '{spag_pkg::CMD_ROOK, 6'd28, 64'h0010_0000_4400_0010, EMPTY_BOARD,
                          1'b0, EMPTY_BOARD};
    directed_rows[14] = '{spag_pkg::CMD_ROOK, 6'd28, 64'h0010_0000_5400_0010, EMPTY_BOARD,
                          1'b0, EMPTY_BOARD};
    // Blockers outside occupancy become occupied for the second pass.
    directed_rows[15] = '{spag_pkg::CMD_XRAY_BISHOP, 6'd27, 64'h0000_0020_0004_0000,
                          64'h0040_0000_0000_0200, 1'b0, EMPTY_BOARD};
    directed_rows[16] = '{spag_pkg::CMD_XRAY_ROOK, 6'd36, 64'h1000_0010_a600_1010,
                          EMPTY_BOARD, 1'b0, EMPTY_BOARD};
    directed_rows[17] = '{spag_pkg::CMD_XRAY_BISHOP, 6'd0, EMPTY_BOARD, FULL_BOARD, 1'b0,
                          EMPTY_BOARD};
    directed_rows[18] = '{spag_pkg::CMD_ROOK, 6'd56, 64'h2300_0001_0000_0100, EMPTY_BOARD,
                          1'b0, EMPTY_BOARD};
    directed_rows[19] = '{spag_pkg::CMD_QUEEN, 6'd63, FULL_BOARD, FULL_BOARD, 1'b0,
                          EMPTY_BOARD};
    directed_rows[20] = '{spag_pkg::CMD_XRAY_ROOK, 6'd63, 64'h5555555555555555,
                          64'haaaaaaaaaaaaaaaa, 1'b0, EMPTY_BOARD};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    gap_pct = 37;
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      row = directed_rows[i];
      issue(row.cmd, row.sq, row.occ, row.blk, row.known, row.want);
    end
    drain();

    for (phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd = spag_pkg::CMD_W'($urandom_range(5, 7));
        end else begin
          cmd = spag_pkg::CMD_W'($urandom_range(0, 4));
        end
        sq  = spag_pkg::SQ_W'($urandom_range(0, 63));
        occ = sample_board();
        occ[sq] = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 7) begin
          blk = occ & sample_board();
        end else begin
          blk = sample_board();
        end
        issue(cmd, sq, occ, blk, 1'b0, EMPTY_BOARD);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d queries (%0d x-ray), %0d results checked, %0d cycles.",
             sent, xray_sent, checked, cycle_count);
    $display("Directed corners, spare codes, then three idle patterns of random boards.");
    if (mismatches == 0 && pending_attacks.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
